/* rtl/lpbf_pkg.sv */
`default_nettype none
package lpbf_pkg;
  localparam int unsigned MaxNodes = 4096;
  localparam int unsigned MaxEdges = 8192;
  localparam int unsigned NodeW = $clog2(MaxNodes);
  localparam int unsigned EdgeW = $clog2(MaxEdges);
  localparam int unsigned CntW = EdgeW + 1;
  localparam int unsigned NcW = 13;

  typedef struct packed {
    logic [11:0] from_node;
    logic [11:0] to_node;
    logic signed [31:0] edge_weight;
    logic last_edge;
  } edge_req_t;

  typedef struct packed {
    logic signed [63:0] best_score;
    logic unbounded_flag;
    logic unreachable_flag;
    logic overflow_flag;
  } result_t;

  typedef enum logic [3:0] {
    StIdle, StClear, StReach, StInit, StRelax, StCheck, StFinal, StOut
  } state_e;

  // Sweep kinds executed by the datapath.
  typedef enum logic [1:0] {
    SwReach, SwRelax, SwCheck
  } sweep_e;

  typedef struct packed {
    logic   clear_start;
    logic   sweep_start;
    sweep_e sweep_kind;
    logic   final_read;
    logic   result_load;
    logic   store_reset;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic sweep_done;
    logic changed;
    logic hit;
    logic final_done;
  } status_t;
endpackage
`default_nettype wire

/* rtl/lpbf_datapath.sv */
`default_nettype none
module lpbf_datapath
  import lpbf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  var  edge_req_t          edge_i,
  input  wire logic [NodeW:0]     n_i,
  input  var  cmd_t               cmd_i,
  output      status_t            status_o,
  output      result_t            result_o
);
  logic [11:0]        src_mem [MaxEdges];
  logic [11:0]        dst_mem [MaxEdges];
  logic signed [31:0] wgt_mem [MaxEdges];
  logic signed [63:0] score_mem [MaxNodes];
  logic               reach_mem [MaxNodes];
  logic               reached_mem [MaxNodes];

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;

  // Sweep pipeline: stage 0 issues an edge read, stage 1 holds edge fields and
  // issues node reads, stage 2 evaluates and writes back.
  logic [CntW-1:0] k_q;
  logic            act_q, s1_q, s2_q;
  sweep_e          kind_q;
  logic [11:0]     a1_q, b1_q;
  logic signed [31:0] w1_q;
  logic            ok1_q;
  logic [NodeW-1:0] a2_q, b2_q;
  logic signed [31:0] w2_q;
  logic            ok2_q;
  logic signed [63:0] sa_q, sb_q;
  logic            ra_q, rb_q, ta_q, tb_q;
  logic            changed_q, hit_q, done_q;
  logic [NodeW:0]  clr_q;
  logic            clr_act_q, clr_done_q;
  logic            fin_q;
  logic signed [63:0] fscore_q;
  logic            freach_q;
  result_t         res_q;

  // Stage 2 evaluation of the edge in flight.
  logic            wr_score, wr_reach;
  logic signed [63:0] cand;
  logic signed [63:0] wext;
  logic signed [64:0] sum;
  logic [NodeW-1:0] tgt;
  logic signed [63:0] sa_f, sb_f;
  logic            ra_f, rb_f, ta_f, tb_f;
  logic [NodeW-1:0] rd_a;

  assign tgt = n_i[NodeW-1:0] - NodeW'(1);

  // The final read borrows the source-node port to fetch the target entry.
  assign rd_a = cmd_i.final_read ? tgt : a1_q[NodeW-1:0];

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (load_i) begin
      if (cnt_q < CntW'(MaxEdges)) cnt_d = cnt_q + CntW'(1);
      else ovf_d = 1'b1;
    end
    if (cmd_i.store_reset) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_comb begin
    wext = 64'(w2_q);
    sum = 65'(sa_f) + 65'(wext);
    if (sum[64] != sum[63]) cand = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else cand = sum[63:0];
    wr_score = 1'b0;
    wr_reach = 1'b0;
    if (s2_q && ok2_q && !hit_q) begin
      if (kind_q == SwReach) begin
        wr_reach = tb_f && !ta_f;
      end else if (ra_f && (!rb_f || cand > sb_f)) begin
        wr_score = !(kind_q == SwCheck && tb_f);
      end
    end
  end

  // Only one edge is in flight, so a write-back always lands before the
  // next edge reads its nodes.
  always_comb begin
    sa_f = sa_q; sb_f = sb_q; ra_f = ra_q; rb_f = rb_q; ta_f = ta_q; tb_f = tb_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_i && cnt_q < CntW'(MaxEdges)) begin
      src_mem[cnt_q[EdgeW-1:0]] <= edge_i.from_node;
      dst_mem[cnt_q[EdgeW-1:0]] <= edge_i.to_node;
      wgt_mem[cnt_q[EdgeW-1:0]] <= edge_i.edge_weight;
    end
    a1_q <= src_mem[k_q[EdgeW-1:0]];
    b1_q <= dst_mem[k_q[EdgeW-1:0]];
    w1_q <= wgt_mem[k_q[EdgeW-1:0]];
  end

  logic ok1;
  assign ok1 = (13'(a1_q) < 13'(n_i)) && (13'(b1_q) < 13'(n_i));

  logic [NodeW-1:0] clr_addr;
  assign clr_addr = clr_q[NodeW-1:0];

  always_ff @(posedge clk_i) begin
    sa_q <= score_mem[rd_a];
    sb_q <= score_mem[b1_q[NodeW-1:0]];
    ra_q <= reached_mem[rd_a];
    rb_q <= reached_mem[b1_q[NodeW-1:0]];
    ta_q <= reach_mem[a1_q[NodeW-1:0]];
    tb_q <= reach_mem[b1_q[NodeW-1:0]];
    if (fin_q) begin
      fscore_q <= sa_q;
      freach_q <= ra_q;
    end
    a2_q <= a1_q[NodeW-1:0];
    b2_q <= b1_q[NodeW-1:0];
    w2_q <= w1_q;
    ok2_q <= ok1;
    if (clr_act_q) begin
      reach_mem[clr_addr] <= (clr_addr == tgt);
      reached_mem[clr_addr] <= (clr_addr == '0);
      score_mem[clr_addr] <= '0;
    end else if (wr_reach) begin
      reach_mem[a2_q] <= 1'b1;
    end else if (wr_score) begin
      score_mem[b2_q] <= cand;
      reached_mem[b2_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; ovf_q <= 1'b0;
      k_q <= '0; act_q <= 1'b0; s1_q <= 1'b0; s2_q <= 1'b0;
      kind_q <= SwReach; changed_q <= 1'b0; hit_q <= 1'b0; done_q <= 1'b0;
      clr_q <= '0; clr_act_q <= 1'b0; clr_done_q <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      done_q <= 1'b0;
      clr_done_q <= 1'b0;
      fin_q <= cmd_i.final_read;
      if (cmd_i.clear_start) begin
        clr_q <= '0;
        clr_act_q <= 1'b1;
      end else if (clr_act_q) begin
        if (clr_q == n_i - (NodeW+1)'(1)) begin
          clr_act_q <= 1'b0;
          clr_done_q <= 1'b1;
        end
        clr_q <= clr_q + (NodeW+1)'(1);
      end
      if (cmd_i.sweep_start) begin
        k_q <= '0;
        kind_q <= cmd_i.sweep_kind;
        act_q <= (cnt_q != '0);
        changed_q <= 1'b0;
        hit_q <= 1'b0;
        s1_q <= 1'b0;
        s2_q <= 1'b0;
        if (cnt_q == '0) done_q <= 1'b1;
      end else begin
        // Only one edge in flight at a time keeps read-after-write exact.
        s1_q <= act_q && !s1_q && !s2_q;
        s2_q <= s1_q;
        if (s2_q) begin
          if (wr_reach || wr_score) changed_q <= 1'b1;
          if (kind_q == SwCheck && ok2_q && ra_f && (!rb_f || cand > sb_f) && tb_f)
            hit_q <= 1'b1;
          if (k_q + CntW'(1) == cnt_q) begin
            act_q <= 1'b0;
            done_q <= 1'b1;
          end
          k_q <= k_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      res_q.best_score <= '0;
      res_q.unbounded_flag <= hit_q;
      res_q.unreachable_flag <= !hit_q && !freach_q;
      res_q.overflow_flag <= ovf_q;
      if (!hit_q && freach_q) res_q.best_score <= fscore_q;
    end
  end

  assign status_o.clear_done = clr_done_q;
  assign status_o.sweep_done = done_q;
  assign status_o.changed = changed_q;
  assign status_o.hit = hit_q;
  assign status_o.final_done = fin_q;
  assign result_o = res_q;
endmodule
`default_nettype wire

/* rtl/lpbf_ctrl.sv */
`default_nettype none
module lpbf_ctrl
  import lpbf_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           last_i,
  input  wire logic [NodeW:0] n_i,
  input  var  status_t        status_i,
  input  wire logic           out_taken_i,
  output      cmd_t           cmd_o,
  output      logic           busy_o,
  output      logic           out_valid_o
);
  state_e state_q, state_d;
  logic [NodeW:0] round_q, round_d;

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    case (state_q)
      StIdle: if (last_i) state_d = StClear;
      StClear: if (status_i.clear_done) begin
        state_d = StReach;
        round_d = '0;
      end
      StReach: if (status_i.sweep_done) begin
        round_d = round_q + (NodeW+1)'(1);
        if (!status_i.changed || round_q + (NodeW+1)'(1) >= n_i) begin
          state_d = StRelax;
          round_d = (NodeW+1)'(1);
        end
      end
      StRelax: if (status_i.sweep_done || round_q >= n_i) begin
        round_d = round_q + (NodeW+1)'(1);
        if (round_q >= n_i || !status_i.changed || round_q + (NodeW+1)'(1) >= n_i)
          state_d = StCheck;
      end
      StCheck: if (status_i.sweep_done) state_d = StFinal;
      StFinal: if (status_i.final_done) state_d = StInit;
      StInit: state_d = StOut;
      StOut: if (out_taken_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // A sweep is started on entry to a sweeping state and after each done.
  logic start_q;
  always_comb begin
    cmd_o = '0;
    cmd_o.sweep_kind = SwReach;
    case (state_q)
      StIdle: cmd_o.clear_start = last_i;
      StReach: begin
        cmd_o.sweep_kind = SwReach;
        cmd_o.sweep_start = start_q;
      end
      StRelax: begin
        cmd_o.sweep_kind = SwRelax;
        cmd_o.sweep_start = start_q && round_q < n_i;
      end
      StCheck: begin
        cmd_o.sweep_kind = SwCheck;
        cmd_o.sweep_start = start_q;
      end
      StFinal: cmd_o.final_read = start_q;
      StInit: begin
        cmd_o.result_load = 1'b1;
        cmd_o.store_reset = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      round_q <= '0;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      start_q <= (state_d != state_q) || status_i.sweep_done;
    end
  end
endmodule
`default_nettype wire

/* rtl/longest_path_bellman_ford.sv */
`default_nettype none
// Longest path with positive-cycle check. Edge requests are taken one per
// cycle and stored in on-chip memory; the request carrying last_edge starts
// the computation, and no request is taken until its result has been taken.
// Computing runs a node clearing pass over node_count entries, then reverse
// reachability sweeps, up to node_count-1 relaxation sweeps and one check
// sweep; a sweep takes the stored edges one by one, a single edge in flight
// at a time in the shared read-modify-write datapath. The user must write
// node_count through the cfg port while idle (unenforced); 0 acts as 1.
module longest_path_bellman_ford
  import lpbf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output      logic         in_stall_o,
  input  var  edge_req_t    in_data_i,
  output      logic         out_valid_o,
  input  wire logic         out_stall_i,
  output      result_t      out_data_o,
  input  wire logic         cfg_valid_i,
  output      logic         cfg_ready_o,
  input  wire logic [NcW-1:0] cfg_data_i
);
  logic [NcW-1:0] nc_q;
  logic [NodeW:0] n_eff;
  logic busy, load;
  cmd_t cmd;
  status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) nc_q <= NcW'(1);
    else if (cfg_valid_i) nc_q <= cfg_data_i;
  end
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (nc_q == '0) n_eff = (NodeW+1)'(1);
    else if (nc_q > NcW'(MaxNodes)) n_eff = (NodeW+1)'(MaxNodes);
    else n_eff = nc_q[NodeW:0];
  end

  assign in_stall_o = busy;
  assign load = in_valid_i && !busy;

  lpbf_datapath u_dp (
    .clk_i, .rst_ni, .load_i(load), .edge_i(in_data_i), .n_i(n_eff),
    .cmd_i(cmd), .status_o(status), .result_o(out_data_o)
  );

  lpbf_ctrl u_ctrl (
    .clk_i, .rst_ni, .last_i(load && in_data_i.last_edge), .n_i(n_eff),
    .status_i(status), .out_taken_i(!out_stall_i), .cmd_o(cmd),
    .busy_o(busy), .out_valid_o(out_valid_o)
  );
endmodule
`default_nettype wire
